// File: rtl/core/ecsc_pkg.sv
// ----------------------------------------------------------------------------
// ecsc_pkg
// Shared types and constants for the elevator car SCAN controller.
// ----------------------------------------------------------------------------
package ecsc_pkg;

	localparam int MaxRun  = 5;                    // longest command run per item
	localparam int RunCntW = $clog2(MaxRun + 1);
	localparam int RunIdxW = $clog2(MaxRun);
	localparam int FloorW  = 4;

	typedef enum logic [1:0] {
		ACT_ARRIVAL = 2'd0,
		ACT_HALL    = 2'd1,
		ACT_CABIN   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		CMD_STOP  = 3'd0,
		CMD_OPEN  = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_UP    = 3'd3,
		CMD_DOWN  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		action_t           action;
		logic [FloorW-1:0] floor;
	} item_t;

	typedef struct packed {
		cmd_t command;
		logic last;
	} result_t;

	// One queued run of commands, cmds[0] goes out first
	typedef struct packed {
		logic [RunCntW-1:0]      count;
		cmd_t [MaxRun-1:0]       cmds;
	} run_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} rq_status_t;

endpackage

// File: rtl/core/ecsc_front.sv
// ----------------------------------------------------------------------------
// ecsc_front
// Accepts items, updates floor, direction and stop mask, and builds the
// command run for each item.
// ----------------------------------------------------------------------------
module ecsc_front #(
	parameter int FLOOR_COUNT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  ecsc_pkg::item_t item,
	input  logic            rq_full,
	output logic            push,
	output ecsc_pkg::run_t  push_run
);
	import ecsc_pkg::*;

	logic [FloorW-1:0]      cur_q, nxt_cur;
	dir_t                   dir_q, nxt_dir;
	logic [FLOOR_COUNT-1:0] mask_q, nxt_mask;

	logic [FLOOR_COUNT-1:0] onehot, above, below, clr, set;
	logic                   hit, floor_ok, accept;
	run_t                   run;

	always_comb begin
		for (int i = 0; i < FLOOR_COUNT; i++) begin
			onehot[i] = (int'(item.floor) == i);
			above[i]  = (int'(item.floor) < i);
			below[i]  = (int'(item.floor) > i);
		end
	end

	assign floor_ok = |onehot;
	assign hit      = |(mask_q & onehot);
	assign clr      = mask_q & ~onehot;
	assign set      = mask_q | onehot;

	always_comb begin
		run      = '0;
		nxt_cur  = cur_q;
		nxt_dir  = dir_q;
		nxt_mask = mask_q;
		if (floor_ok) begin
			case (item.action)
				ACT_ARRIVAL: begin
					nxt_cur = item.floor;
					if (hit) begin
						run.cmds[0] = CMD_STOP;
						run.cmds[1] = CMD_OPEN;
						run.cmds[2] = CMD_CLOSE;
						run.count   = RunCntW'(3);
						nxt_mask    = clr;
						if (clr == '0) begin
							run.cmds[3] = CMD_STOP;
							run.count   = RunCntW'(4);
							nxt_dir     = DIR_IDLE;
						end else if (dir_q == DIR_UP) begin
							run.cmds[3] = CMD_CLOSE;
							run.count   = RunCntW'(5);
							if (|(clr & above)) begin
								run.cmds[4] = CMD_UP;
							end else begin
								run.cmds[4] = CMD_DOWN;
								nxt_dir     = DIR_DOWN;
							end
						end else if (dir_q == DIR_DOWN) begin
							run.cmds[3] = CMD_CLOSE;
							run.count   = RunCntW'(5);
							if (|(clr & below)) begin
								run.cmds[4] = CMD_DOWN;
							end else begin
								run.cmds[4] = CMD_UP;
								nxt_dir     = DIR_UP;
							end
						end
					end else if (dir_q == DIR_UP) begin
						run.cmds[0] = CMD_UP;
						run.count   = RunCntW'(1);
					end else if (dir_q == DIR_DOWN) begin
						run.cmds[0] = CMD_DOWN;
						run.count   = RunCntW'(1);
					end
				end
				ACT_HALL, ACT_CABIN: begin
					nxt_mask = set;
					if (dir_q == DIR_IDLE) begin
						if (item.floor > cur_q) begin
							run.cmds[0] = CMD_CLOSE;
							run.cmds[1] = CMD_UP;
							run.count   = RunCntW'(2);
							nxt_dir     = DIR_UP;
						end else if (item.floor < cur_q) begin
							run.cmds[0] = CMD_CLOSE;
							run.cmds[1] = CMD_DOWN;
							run.count   = RunCntW'(2);
							nxt_dir     = DIR_DOWN;
						end else begin
							// called at the floor the idle car stands on
							run.cmds[0] = CMD_STOP;
							run.cmds[1] = CMD_OPEN;
							run.cmds[2] = CMD_CLOSE;
							run.count   = RunCntW'(3);
							nxt_mask    = clr;
						end
					end else if (item.action == ACT_CABIN) begin
						run.cmds[0] = (dir_q == DIR_UP) ? CMD_UP : CMD_DOWN;
						run.count   = RunCntW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign item_ready = !rq_full;
	assign accept     = item_valid && item_ready;
	assign push       = accept && (run.count != '0);
	assign push_run   = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			dir_q  <= DIR_IDLE;
			mask_q <= '0;
		end else if (accept) begin
			cur_q  <= nxt_cur;
			dir_q  <= nxt_dir;
			mask_q <= nxt_mask;
		end
	end

endmodule

// File: rtl/core/ecsc_run_queue.sv
// ----------------------------------------------------------------------------
// ecsc_run_queue
// Two-entry queue of command runs between front and back.
// ----------------------------------------------------------------------------
module ecsc_run_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ecsc_pkg::run_t       push_run,
	input  logic                 pop,
	output ecsc_pkg::rq_status_t status,
	output ecsc_pkg::run_t       head
);
	import ecsc_pkg::*;

	run_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign status.full       = (cnt_q == 2'd2);
	assign status.head_valid = (cnt_q != 2'd0);
	assign head              = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_run;
		end
	end

endmodule

// File: rtl/core/ecsc_back.sv
// ----------------------------------------------------------------------------
// ecsc_back
// Steps the head run into the output register, one command per cycle unless stalled.
// ----------------------------------------------------------------------------
module ecsc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ecsc_pkg::run_t      head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output ecsc_pkg::result_t   result
);
	import ecsc_pkg::*;

	logic [RunIdxW-1:0] idx_q;
	logic               valid_q;
	result_t            result_q;
	logic               can_load, is_last;
	cmd_t               cur_cmd;

	assign can_load = !valid_q || result_ready;
	assign cur_cmd  = head.cmds[idx_q];
	assign is_last  = (RunCntW'(idx_q) + RunCntW'(1)) == head.count;
	assign pop      = can_load && head_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (can_load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? '0 : idx_q + RunIdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && head_valid) begin
			result_q.command <= cur_cmd;
			result_q.last    <= is_last;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// File: rtl/core/elevator_car_scan_controller.sv
// ----------------------------------------------------------------------------
// elevator_car_scan_controller
// One elevator car under a SCAN policy: arrival reports and calls in,
// motor and door commands out.
// ----------------------------------------------------------------------------
//  channel  | direction | payload             | handshake
//  item     | in        | action, floor       | item_valid / item_ready
//  result   | out       | command, last       | result_valid / result_ready
//
// An item is taken whenever the two-entry run queue has room; its state
// update lands at that edge. Each command run passes through the run queue
// and then the output register, and commands leave one per cycle while
// result_ready is high. An item makes up to 5 commands, or none. A
// stalled result holds the back end only; the front keeps taking items until
// the queue fills. Reset clears floor, direction and stops.
// ----------------------------------------------------------------------------
module elevator_car_scan_controller #(
	parameter int FLOOR_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ecsc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output ecsc_pkg::result_t result
);
	import ecsc_pkg::*;

	logic       push, pop;
	run_t       push_run, head;
	rq_status_t rq_status;

	ecsc_front #(
		.FLOOR_COUNT(FLOOR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rq_full    (rq_status.full),
		.push       (push),
		.push_run   (push_run)
	);

	ecsc_run_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.status   (rq_status),
		.head     (head)
	);

	ecsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (rq_status.head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// a stalled front means a full queue, which must have a run at its head
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> rq_status.head_valid)
		else $error("front stalled with no queued run");

	// queued runs are never empty nor longer than the longest run
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		rq_status.head_valid |-> (head.count != '0) && (head.count <= RunCntW'(MaxRun)))
		else $error("queued run has bad length");

	// the rest of a run follows straight after a taken non-final command
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last |=> result_valid)
		else $error("gap inside a command run");
`endif

endmodule

// File: dv/elevator_car_scan_controller_tb.sv
// ----------------------------------------------------------------------------
// elevator_car_scan_controller_tb
// Self-checking bench for the SCAN elevator controller. A directed walk takes
// the car up, down, through reversals and back to idle, then random traffic
// follows in four idling phases. Traffic is mostly plausible car movement plus
// calls, with some noise. Each command is compared against its row's typed-in
// commands, else a behavioural model of car floor, direction and pending stops.
// ----------------------------------------------------------------------------
module elevator_car_scan_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ecsc_pkg::*;

	localparam logic [1:0] ACT_UNDEF = 2'd3;   // no such action, item is dropped
	localparam int PREDICTED = -1;              // row has no typed-in commands
	localparam int RANDOM_PER_PHASE = 100;
	localparam int SEND_IDLE [4] = '{0, 65, 0, 15};
	localparam int RECV_STALL [4] = '{0, 0, 65, 15};

	typedef struct packed {
		logic [1:0] act;
		logic [3:0] flr;
		int         n;
		cmd_t       c0, c1, c2, c3, c4;
	} step_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// model of the car
	logic [3:0]  car_floor;
	dir_t        car_dir;
	logic [15:0] car_stops;

	cmd_t    planned [$];
	result_t cmds_due [$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	step_t directed [23] = '{
		'{ACT_ARRIVAL, 4'd0,  0,         CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_HALL,    4'd0,  3,         CMD_STOP,  CMD_OPEN, CMD_CLOSE, CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd15, 2,         CMD_CLOSE, CMD_UP,   CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_HALL,    4'd7,  0,         CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd3,  1,         CMD_UP,    CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd1,  1,         CMD_UP,    CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd3,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_UNDEF,   4'd5,  0,         CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd15, PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd12, PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd12, PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_HALL,    4'd2,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd7,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd9,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd2,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd9,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_HALL,    4'd0,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd0,  PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd15, PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd15, PREDICTED, CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_UNDEF,   4'd15, 0,         CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP},
		'{ACT_CABIN,   4'd15, 3,         CMD_STOP,  CMD_OPEN, CMD_CLOSE, CMD_STOP, CMD_STOP},
		'{ACT_ARRIVAL, 4'd15, 0,         CMD_STOP,  CMD_STOP, CMD_STOP,  CMD_STOP, CMD_STOP}
	};

	elevator_car_scan_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Updates the car model for one transaction and leaves its commands in planned
	function automatic void plan_commands(input item_t it);
		logic [15:0] flr_bit;
		flr_bit = 16'd1 << it.floor;
		planned = {};
		if (it.action == ACT_ARRIVAL) begin
			car_floor = it.floor;
			if ((car_stops & flr_bit) == '0) begin
				if (car_dir == DIR_UP) planned.push_back(CMD_UP);
				else if (car_dir == DIR_DOWN) planned.push_back(CMD_DOWN);
			end else begin
				planned.push_back(CMD_STOP);
				planned.push_back(CMD_OPEN);
				planned.push_back(CMD_CLOSE);
				car_stops &= ~flr_bit;
				if (car_stops == '0) begin
					planned.push_back(CMD_STOP);
					car_dir = DIR_IDLE;
				end else if (car_dir == DIR_UP) begin
					planned.push_back(CMD_CLOSE);
					// no stop left above: turn round
					if ((32'(car_stops) >> (int'(car_floor) + 1)) != 0) begin
						planned.push_back(CMD_UP);
					end else begin
						planned.push_back(CMD_DOWN);
						car_dir = DIR_DOWN;
					end
				end else if (car_dir == DIR_DOWN) begin
					planned.push_back(CMD_CLOSE);
					if ((car_stops & ((16'd1 << car_floor) - 16'd1)) != '0) begin
						planned.push_back(CMD_DOWN);
					end else begin
						planned.push_back(CMD_UP);
						car_dir = DIR_UP;
					end
				end
			end
		end else if (it.action == ACT_HALL || it.action == ACT_CABIN) begin
			car_stops |= flr_bit;
			if (car_dir == DIR_IDLE) begin
				if (it.floor > car_floor) begin
					planned.push_back(CMD_CLOSE);
					planned.push_back(CMD_UP);
					car_dir = DIR_UP;
				end else if (it.floor < car_floor) begin
					planned.push_back(CMD_CLOSE);
					planned.push_back(CMD_DOWN);
					car_dir = DIR_DOWN;
				end else begin
					planned.push_back(CMD_STOP);
					planned.push_back(CMD_OPEN);
					planned.push_back(CMD_CLOSE);
					car_stops &= ~flr_bit;
				end
			end else if (it.action == ACT_CABIN) begin
				planned.push_back(car_dir == DIR_UP ? CMD_UP : CMD_DOWN);
			end
		end
	endfunction

	function automatic void queue_run();
		foreach (planned[i]) cmds_due.push_back('{planned[i], 1'(i == planned.size() - 1)});
	endfunction

	// Mostly plausible traffic: calls while idle, next-floor arrivals while moving
	function automatic item_t pick_item();
		logic [1:0] act;
		logic [3:0] flr;
		int         roll;
		roll = $urandom_range(99);
		act = ACT_ARRIVAL;
		flr = 4'($urandom_range(15));
		if (roll < 12) act = 2'($urandom_range(3));
		else if (car_dir == DIR_IDLE || roll < 40) act = roll[0] ? ACT_HALL : ACT_CABIN;
		else if (car_dir == DIR_UP && car_floor != 4'd15) flr = car_floor + 4'd1;
		else if (car_dir == DIR_DOWN && car_floor != 4'd0) flr = car_floor - 4'd1;
		return {act, flr};
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_item(input item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (cmds_due.size() != 0);
	endtask

	always @(posedge clk) result_ready <= ($urandom_range(99) >= recv_stall_pct);

	// handshake values are stable at the falling edge ahead of the accepting edge
	always @(negedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (cmds_due.size() == 0) begin
				$error("command with none outstanding: command %0d last %0d",
					result.command, result.last);
				mismatches++;
			end else begin
				want = cmds_due.pop_front();
				if (result.command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, result.command);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		item_t it;
		cmd_t  typed [5];
		int    taken;
		car_floor = '0;
		car_dir = DIR_IDLE;
		car_stops = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			it = {directed[r].act, directed[r].flr};
			send_item(it);
			plan_commands(it);
			if (directed[r].n != PREDICTED) begin
				typed = '{directed[r].c0, directed[r].c1, directed[r].c2, directed[r].c3,
					directed[r].c4};
				planned = {};
				for (int i = 0; i < directed[r].n; i++) planned.push_back(typed[i]);
			end
			queue_run();
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			taken = 0;
			while (taken < RANDOM_PER_PHASE) begin
				it = pick_item();
				send_item(it);
				plan_commands(it);
				queue_run();
				if (it.action != ACT_UNDEF) taken++;
			end
			// sender holds off until the car has caught up
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/core/ecsc_pkg.sv
rtl/core/ecsc_front.sv
rtl/core/ecsc_run_queue.sv
rtl/core/ecsc_back.sv
rtl/core/elevator_car_scan_controller.sv
dv/elevator_car_scan_controller_tb.sv
